/* rtl/core/touch_key_baseline_and_detect_macros.svh */
// Assertion helpers used by the touch key top level.
`ifndef TOUCH_KEY_BASELINE_AND_DETECT_MACROS_SVH
`define TOUCH_KEY_BASELINE_AND_DETECT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define TKBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("touch key check failed");

// Next-cycle implication, off while reset is asserted.
`define TKBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("touch key check failed");

`endif

/* rtl/core/tkbd_pkg.sv */
`default_nettype none
package tkbd_pkg;

  // Sample and register widths
  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SCAN_W    = 4;

  // Entries dropped at each end of the sorted calibration set
  localparam int TRIM = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GATE = 2'd0,
    CFG_FULL = 2'd1,
    CFG_SCAN = 2'd2
  } cfg_reg_e;

  // Input opcodes and result kinds
  localparam logic OP_CAL    = 1'b0;
  localparam logic OP_SCAN   = 1'b1;
  localparam logic KIND_CAL  = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic ins_step;
    logic sum_step;
    logic div_step;
    logic scan_step;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ins_done;
    logic cal_full;
    logic sum_last;
    logic scan_due;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

/* rtl/core/tkbd_ctrl.sv */
`default_nettype none
module tkbd_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_opcode_i,
  output logic                    in_ready_o,
  input  wire tkbd_pkg::dp_stat_t stat_i,
  output tkbd_pkg::dp_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    IDLE,
    INSERT,
    SUM,
    DIVIDE,
    SCAN,
    EMIT
  } state_e;

  state_e state_q, state_d;

  // Decode commands and next state
  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = (state_q == IDLE);
    case (state_q)
      IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = (in_opcode_i == tkbd_pkg::OP_SCAN) ? SCAN : INSERT;
        end
      end
      INSERT: begin
        cmd_o.ins_step = 1'b1;
        if (stat_i.ins_done) begin
          state_d = stat_i.cal_full ? SUM : IDLE;
        end
      end
      SUM: begin
        cmd_o.sum_step = 1'b1;
        if (stat_i.sum_last) begin
          state_d = DIVIDE;
        end
      end
      DIVIDE: begin
        cmd_o.div_step = 1'b1;
        state_d = EMIT;
      end
      SCAN: begin
        cmd_o.scan_step = 1'b1;
        state_d = stat_i.scan_due ? EMIT : IDLE;
      end
      EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = IDLE;
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/tkbd_datapath.sv */
`default_nettype none
module tkbd_datapath #(
  parameter int CAL_SAMPLES = 10
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration writes
  input  wire logic                                 cfg_we_i,
  input  wire logic [tkbd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [tkbd_pkg::CFG_W-1:0]           cfg_data_i,
  // input item payload
  input  wire logic                                 opcode_i,
  input  wire logic [tkbd_pkg::SAMPLE_W-1:0]        sample_i,
  // result item
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      result_kind_o,
  output logic                                      touched_o,
  output logic [tkbd_pkg::SAMPLE_W-1:0]             peak_value_o,
  output logic [tkbd_pkg::SAMPLE_W-1:0]             baseline_value_o,
  output logic                                      calib_fault_o,
  // controller link
  input  wire tkbd_pkg::dp_cmd_t                    cmd_i,
  output tkbd_pkg::dp_stat_t                        stat_o
);

  localparam int SW       = tkbd_pkg::SAMPLE_W;
  localparam int IDX_W    = $clog2(CAL_SAMPLES);
  localparam int SUM_W    = SW + $clog2(CAL_SAMPLES);
  localparam int DIVISOR  = CAL_SAMPLES - 2 * tkbd_pkg::TRIM;
  // Reciprocal scale: 4 spare bits keep the rounding error below one step
  localparam int RECIP_SH = SUM_W + 4;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << RECIP_SH) + DIVISOR - 1) / DIVISOR);
  localparam int SCW      = tkbd_pkg::SCAN_W;

  // Sorted calibration entries and sequencing registers
  logic [SW-1:0]     store_q [CAL_SAMPLES];
  logic [SW-1:0]     store_d [CAL_SAMPLES];
  logic              op_q, op_d;
  logic [SW-1:0]     val_q, val_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]  num_q, num_d;

  // Persistent state and configuration
  logic [IDX_W-1:0]  fill_q, fill_d;
  logic [SW-1:0]     baseline_q, baseline_d;
  logic [SW-1:0]     peak_q, peak_d;
  logic [SCW-1:0]    sfill_q, sfill_d;
  logic [SW-1:0]     gate_q, full_q;
  logic [SCW-1:0]    scnt_q;

  // Result register
  logic              out_valid_q;
  logic              kind_q, touched_q, fault_q;
  logic [SW-1:0]     peak_out_q, base_out_q;

  // Combinational helpers
  logic [IDX_W-1:0]  rd_addr;
  logic [SW-1:0]     rd_data;
  logic [PROD_W-1:0] quot_prod;
  logic [SCW-1:0]    need;
  logic [SCW-1:0]    sfill_inc;
  logic [SW:0]       gate_sum;
  logic              hit;
  logic              fault;

  // Read the entry below the insert point, or the next entry to sum
  assign rd_addr = cmd_i.sum_step ? ptr_q : ptr_q - IDX_W'(1);
  assign rd_data = store_q[rd_addr];

  // Divide the middle sum by scaling with the divisor's reciprocal
  assign quot_prod = PROD_W'(num_q) * PROD_W'(RECIP);

  // Scan group length, zero counts as one
  assign need      = (scnt_q == '0) ? SCW'(1) : scnt_q;
  assign sfill_inc = (sfill_q == '1) ? sfill_q : sfill_q + SCW'(1);

  // Decision compares
  assign gate_sum = {1'b0, baseline_q} + {1'b0, gate_q};
  assign hit      = ({1'b0, peak_q} > gate_sum);
  assign fault    = (baseline_q > {1'b0, full_q[SW-1:1]});

  // Status to controller
  assign stat_o.ins_done = (ptr_q == '0) || !(rd_data > val_q);
  assign stat_o.cal_full = (fill_q == IDX_W'(CAL_SAMPLES - 1));
  assign stat_o.sum_last = (ptr_q == IDX_W'(CAL_SAMPLES - tkbd_pkg::TRIM - 1));
  assign stat_o.scan_due = (sfill_inc >= need);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // Next values of the working and persistent registers
  always_comb begin
    store_d    = store_q;
    op_d       = op_q;
    val_d      = val_q;
    ptr_d      = ptr_q;
    sum_d      = sum_q;
    num_d      = num_q;
    fill_d     = fill_q;
    baseline_d = baseline_q;
    peak_d     = peak_q;
    sfill_d    = sfill_q;

    // Latch the item; a calibration sample drops any partial scan group
    if (cmd_i.accept) begin
      op_d  = opcode_i;
      val_d = sample_i;
      ptr_d = fill_q;
      if (opcode_i == tkbd_pkg::OP_CAL) begin
        peak_d  = '0;
        sfill_d = '0;
      end
    end

    // Shift one larger entry up, or drop the sample into its slot
    if (cmd_i.ins_step) begin
      if (stat_o.ins_done) begin
        store_d[ptr_q] = val_q;
        if (stat_o.cal_full) begin
          fill_d = '0;
          ptr_d  = IDX_W'(tkbd_pkg::TRIM);
          sum_d  = '0;
        end else begin
          fill_d = fill_q + IDX_W'(1);
        end
      end else begin
        store_d[ptr_q] = rd_data;
        ptr_d = ptr_q - IDX_W'(1);
      end
    end

    // Accumulate the middle entries
    if (cmd_i.sum_step) begin
      sum_d = sum_q + SUM_W'(rd_data);
      ptr_d = ptr_q + IDX_W'(1);
      if (stat_o.sum_last) begin
        num_d = sum_q + SUM_W'(rd_data);
      end
    end

    // Take the quotient as the new baseline
    if (cmd_i.div_step) begin
      baseline_d = quot_prod[RECIP_SH +: SW];
    end

    // Track the scan group peak
    if (cmd_i.scan_step) begin
      if (val_q > peak_q) begin
        peak_d = val_q;
      end
      sfill_d = sfill_inc;
    end

    // Close the scan group once its decision goes out
    if (cmd_i.emit && (op_q == tkbd_pkg::OP_SCAN)) begin
      peak_d  = '0;
      sfill_d = '0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    store_q <= store_d;
    op_q    <= op_d;
    val_q   <= val_d;
    ptr_q   <= ptr_d;
    sum_q   <= sum_d;
    num_q   <= num_d;
    if (cmd_i.emit) begin
      if (op_q == tkbd_pkg::OP_SCAN) begin
        kind_q     <= tkbd_pkg::KIND_SCAN;
        touched_q  <= hit;
        peak_out_q <= peak_q;
        fault_q    <= 1'b0;
      end else begin
        kind_q     <= tkbd_pkg::KIND_CAL;
        touched_q  <= 1'b0;
        peak_out_q <= '0;
        fault_q    <= fault;
      end
      base_out_q <= baseline_q;
    end
  end

  // Persistent state, configuration and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      baseline_q  <= '0;
      peak_q      <= '0;
      sfill_q     <= '0;
      gate_q      <= SW'(100);
      full_q      <= '1;
      scnt_q      <= SCW'(3);
      out_valid_q <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      baseline_q <= baseline_d;
      peak_q     <= peak_d;
      sfill_q    <= sfill_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tkbd_pkg::CFG_GATE: gate_q <= cfg_data_i[SW-1:0];
          tkbd_pkg::CFG_FULL: full_q <= cfg_data_i[SW-1:0];
          tkbd_pkg::CFG_SCAN: scnt_q <= cfg_data_i[SCW-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign touched_o        = touched_q;
  assign peak_value_o     = peak_out_q;
  assign baseline_value_o = base_out_q;
  assign calib_fault_o    = fault_q;

endmodule
`default_nettype wire

/* rtl/core/touch_key_baseline_and_detect.sv */
// Channel  | Handshake             | Payload
// ---------+-----------------------+---------------------------------------------
// in       | in_valid_i/in_ready_o | opcode_i, sample_i
// out      | out_valid_o/out_ready_i | result_kind_o, touched_o, peak_value_o,
//          |                       | baseline_value_o, calib_fault_o
// cfg      | cfg_we_i (no wait)    | cfg_idx_i, cfg_data_i
//
// One item at a time. A scan item passes SCAN, then EMIT when it closes a group.
// A calibration item passes INSERT, where it shifts up each of the k larger
// entries (k <= CAL_SAMPLES-1) and then drops into its slot; the item that
// completes the set then passes SUM over the CAL_SAMPLES-4 middle entries, DIVIDE and EMIT.
// The result register frees input and output: a new item is taken while a
// result waits, and only a further result stalls until out_ready_i.
// Reset is asynchronous: baseline, peak and counts clear, configuration
// returns to gate 100, full scale 65535, scan count 3.
`default_nettype none
`include "touch_key_baseline_and_detect_macros.svh"
module touch_key_baseline_and_detect #(
  parameter int CAL_SAMPLES = 10
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [tkbd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [tkbd_pkg::CFG_W-1:0]           cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 opcode_i,
  input  wire logic [tkbd_pkg::SAMPLE_W-1:0]        sample_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      result_kind_o,
  output logic                                      touched_o,
  output logic [tkbd_pkg::SAMPLE_W-1:0]             peak_value_o,
  output logic [tkbd_pkg::SAMPLE_W-1:0]             baseline_value_o,
  output logic                                      calib_fault_o
);

  tkbd_pkg::dp_cmd_t  cmd;
  tkbd_pkg::dp_stat_t stat;

  // Sequence each item
  tkbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (opcode_i),
    .in_ready_o  (in_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Store, sum, divide and decide
  tkbd_datapath #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (opcode_i),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .touched_o        (touched_o),
    .peak_value_o     (peak_value_o),
    .baseline_value_o (baseline_value_o),
    .calib_fault_o    (calib_fault_o),
    .cmd_i            (cmd),
    .stat_o           (stat)
  );

  // Calibration results carry no decision and no peak
  `TKBD_ASSERT_NOW(a_cal_clean, clk_i, rst_ni,
    out_valid_o && (result_kind_o == tkbd_pkg::KIND_CAL),
    !touched_o && (peak_value_o == '0))
  // Scan results never flag a calibration fault
  `TKBD_ASSERT_NOW(a_scan_nofault, clk_i, rst_ni,
    out_valid_o && (result_kind_o == tkbd_pkg::KIND_SCAN), !calib_fault_o)
  // The block is busy the cycle after it takes an item
  `TKBD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni,
    in_valid_i && in_ready_o, !in_ready_o)
  // A result loads only into a free output register
  `TKBD_ASSERT_NOW(a_emit_free, clk_i, rst_ni, cmd.emit,
    !out_valid_o || out_ready_i)

endmodule
`default_nettype wire
